### rtl/core/sdc_pkg.sv
// Shared types and constants of the stick deadzone calibrator.
// Used by the front end, the divider cells, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

  // Field widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  // Divider widths: numerator |offset| * 127 fits 15 bits, |divisor| up to 382
  localparam int unsigned QuoW = 15;
  localparam int unsigned RemW = 15;
  localparam int unsigned DenW = 9;

  // Request latency from accept to result strobe
  localparam int unsigned Latency = QuoW + 2;

  // Output constants
  localparam logic [SampleW-1:0] CentreOut = 8'h80;
  localparam logic [SampleW-1:0] FullOut = 8'hFF;
  localparam logic [SampleW-1:0] ZeroOut = 8'h00;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinRaw = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxRaw = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCenterRaw = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDeadzone = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScaledMode = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvertAxis = 3'd5;

  // Calibration settings handed to the front end
  typedef struct packed {
    logic [SampleW-1:0] min_raw;
    logic [SampleW-1:0] max_raw;
    logic [SampleW-1:0] center_raw;
    logic [SampleW-1:0] deadzone;
    logic               scaled_mode;
    logic               invert_axis;
  } cfg_t;

  // Payload travelling down the divider chain
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            hold;
    logic            fault;
  } div_t;

endpackage

`default_nettype wire

### rtl/core/sdc_front.sv
// Front end of the calibrator: offset, deadzone test, numerator and divisor.
// Depends on sdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [sdc_pkg::SampleW-1:0]   raw_sample_i,
  input  wire sdc_pkg::cfg_t                 cfg_i,
  output logic                               valid_o,
  output sdc_pkg::div_t                      data_o
);

  logic signed [9:0] offs;
  logic signed [9:0] offs_n;
  logic signed [9:0] offs_abs;
  logic signed [9:0] diff;
  logic signed [9:0] diff_abs;
  logic        [7:0] hmag;
  logic signed [9:0] half;
  logic signed [9:0] dz;
  logic signed [9:0] adj;
  logic signed [9:0] adj_abs;
  logic signed [9:0] den;
  logic signed [9:0] den_abs;
  logic [sdc_pkg::QuoW-1:0] amag;
  logic        in_dz;
  logic        den_zero;
  logic        valid_q;
  sdc_pkg::div_t data_d, data_q;

  // Offset from centre, inverted on request
  always_comb begin
    offs     = $signed({2'b00, raw_sample_i}) - $signed({2'b00, cfg_i.center_raw});
    offs_n   = cfg_i.invert_axis ? -offs : offs;
    offs_abs = offs_n[9] ? -offs_n : offs_n;
    dz       = $signed({2'b00, cfg_i.deadzone});
    in_dz    = offs_abs[8:0] < {1'b0, cfg_i.deadzone};
  end

  // Half range, truncated toward zero
  always_comb begin
    diff     = $signed({2'b00, cfg_i.max_raw}) - $signed({2'b00, cfg_i.min_raw});
    diff_abs = diff[9] ? -diff : diff;
    hmag     = diff_abs[8:1];
    half     = diff[9] ? -$signed({2'b00, hmag}) : $signed({2'b00, hmag});
  end

  // Pull the offset toward zero by the deadzone in scaled mode
  always_comb begin
    if (!cfg_i.scaled_mode) begin
      adj = offs_n;
      den = half;
    end else begin
      adj = (!offs_n[9] && (offs_n != 10'sd0)) ? offs_n - dz : offs_n + dz;
      den = half - dz;
    end
    adj_abs  = adj[9] ? -adj : adj;
    den_abs  = den[9] ? -den : den;
    den_zero = (den == 10'sd0);
    // times 127 as shift and subtract
    amag     = {adj_abs[7:0], 7'b0} - {7'b0, adj_abs[7:0]};
  end

  // Build the divider request
  always_comb begin
    data_d.rem   = amag;
    data_d.den   = den_abs[8:0];
    data_d.quo   = '0;
    data_d.neg   = adj[9] ^ den[9];
    data_d.hold  = in_dz || den_zero;
    data_d.fault = !in_dz && den_zero;
  end

  // Register valid with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Register payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/core/sdc_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on sdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdc_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire sdc_pkg::div_t data_i,
  output logic               valid_o,
  output sdc_pkg::div_t      data_o
);

  localparam int unsigned CmpW = sdc_pkg::DenW + sdc_pkg::QuoW;

  logic [CmpW-1:0] shifted;
  logic            take;
  logic            valid_q;
  sdc_pkg::div_t   data_d, data_q;

  // Trial subtract of the divisor at this bit weight
  always_comb begin
    shifted = CmpW'(data_i.den) << Bit;
    take    = {{(CmpW - sdc_pkg::RemW){1'b0}}, data_i.rem} >= shifted;
    data_d  = data_i;
    if (take) begin
      data_d.rem = data_i.rem - shifted[sdc_pkg::RemW-1:0];
    end
    data_d.quo[Bit] = take;
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/core/sdc_back.sv
// Back end of the calibrator: sign, recentre, clamp and result register.
// Depends on sdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire sdc_pkg::div_t               data_i,
  output logic                             done_o,
  output logic [sdc_pkg::SampleW-1:0]      calibrated_o,
  output logic                             divide_fault_o
);

  logic                        big;
  logic [sdc_pkg::SampleW-1:0] val_d, val_q;
  logic                        fault_q;
  logic                        done_q;

  // Recentre on 128 and clamp; quotients of 128 or more saturate
  always_comb begin
    big = |data_i.quo[sdc_pkg::QuoW-1:7];
    priority if (data_i.hold) begin
      val_d = sdc_pkg::CentreOut;
    end else if (big) begin
      val_d = data_i.neg ? sdc_pkg::ZeroOut : sdc_pkg::FullOut;
    end else if (data_i.neg) begin
      val_d = sdc_pkg::CentreOut - {1'b0, data_i.quo[6:0]};
    end else begin
      val_d = sdc_pkg::CentreOut + {1'b0, data_i.quo[6:0]};
    end
  end

  // Strobe register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    fault_q <= data_i.fault;
  end

  assign done_o         = done_q;
  assign calibrated_o   = val_q;
  assign divide_fault_o = fault_q;

endmodule

`default_nettype wire

### rtl/core/stick_deadzone_calibrator.sv
// Top level of the stick deadzone calibrator: settings, front end, divider
// chain and back end. Depends on sdc_pkg, sdc_front, sdc_div_cell, sdc_back.
//
// Use: raise start with a raw 8-bit sample on raw_sample_i; the request is
// taken at any rising edge where start is high and busy is low. busy
// stays low, so one request can be taken in every cycle.
// Each request yields one result: calibrated_o and divide_fault_o are shown
// for exactly one cycle with done_o high. done_o rises once the request has
// passed the register stages below; results come out in request order.
// The 17 register stages are one front-end stage, a chain of 15 divider
// cells (one quotient bit per cell, each a register stage) and one output
// register; a full chain throughput of one result per cycle follows.
// Settings are written through cfg_we_i, cfg_idx_i and cfg_data_i and take
// effect for requests accepted after the write; unknown indexes are dropped.
// Reset clears all settings to their defaults and empties the chain; no
// result comes out of a request that was in flight at reset.
// The receiver cannot stall: results are not held back.
`timescale 1ns / 1ps
`default_nettype none

module stick_deadzone_calibrator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [sdc_pkg::SampleW-1:0]    raw_sample_i,
  output logic                                done_o,
  output logic [sdc_pkg::SampleW-1:0]         calibrated_o,
  output logic                                divide_fault_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [sdc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [sdc_pkg::CfgDataW-1:0]   cfg_data_i
);

  sdc_pkg::cfg_t cfg_q, cfg_d;
  logic          accept;
  logic          cvalid [sdc_pkg::QuoW+1];
  sdc_pkg::div_t cdata  [sdc_pkg::QuoW+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Settings write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdc_pkg::RegMinRaw:     cfg_d.min_raw     = cfg_data_i;
        sdc_pkg::RegMaxRaw:     cfg_d.max_raw     = cfg_data_i;
        sdc_pkg::RegCenterRaw:  cfg_d.center_raw  = cfg_data_i;
        sdc_pkg::RegDeadzone:   cfg_d.deadzone    = cfg_data_i;
        sdc_pkg::RegScaledMode: cfg_d.scaled_mode = cfg_data_i[0];
        sdc_pkg::RegInvertAxis: cfg_d.invert_axis = cfg_data_i[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_raw     <= 8'd0;
      cfg_q.max_raw     <= 8'd255;
      cfg_q.center_raw  <= 8'd128;
      cfg_q.deadzone    <= 8'd0;
      cfg_q.scaled_mode <= 1'b0;
      cfg_q.invert_axis <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Offset, deadzone and divisor
  sdc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .raw_sample_i (raw_sample_i),
    .cfg_i        (cfg_q),
    .valid_o      (cvalid[0]),
    .data_o       (cdata[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar i = 0; i < sdc_pkg::QuoW; i++) begin : g_cell
    sdc_div_cell #(
      .Bit (sdc_pkg::QuoW - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cvalid[i]),
      .data_i  (cdata[i]),
      .valid_o (cvalid[i+1]),
      .data_o  (cdata[i+1])
    );
  end

  // Recentre, clamp and present
  sdc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (cvalid[sdc_pkg::QuoW]),
    .data_i         (cdata[sdc_pkg::QuoW]),
    .done_o         (done_o),
    .calibrated_o   (calibrated_o),
    .divide_fault_o (divide_fault_o)
  );

  // Every accepted request gives a result after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(sdc_pkg::Latency) done_o)
    else $error("request lost in the divider chain");

  // No result without a request the fixed latency earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, sdc_pkg::Latency))
    else $error("result strobe without a matching request");

  // A divide fault always reports the centre value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_fault_o) |-> (calibrated_o == sdc_pkg::CentreOut))
    else $error("divide fault with a value other than centre");

endmodule

`default_nettype wire
